@@ rtl/boc_pkg.sv @@
// Package: shared constants and types for the boxcar / exponential smoother.
`timescale 1ns / 1ps
package boc_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_WINDOW  = 256;
  localparam int ADDR_BITS   = $clog2(MAX_WINDOW);
  localparam int WIN_BITS    = 9;
  localparam int WEIGHT_BITS = 17;
  localparam int TOTAL_BITS  = SAMPLE_BITS + 13;
  localparam int FRAC_BITS   = 16;
  localparam int ACC_BITS    = SAMPLE_BITS + FRAC_BITS;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = WEIGHT_BITS;

  localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = WEIGHT_BITS'(65536);

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cfg_index_t CFG_FILTER_MODE      = 2'd0;
  localparam cfg_index_t CFG_WINDOW_LENGTH    = 2'd1;
  localparam cfg_index_t CFG_SMOOTHING_WEIGHT = 2'd2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

endpackage

@@ rtl/boc_in_if.sv @@
// Interface: input sample channel.
`timescale 1ns / 1ps
interface boc_in_if
  import boc_pkg::*;
;
  logic    valid;
  logic    ready;
  sample_t sample_value;
  logic    record_start;

  modport source (output valid, output sample_value, output record_start, input ready);
  modport sink   (input valid, input sample_value, input record_start, output ready);
endinterface

@@ rtl/boc_out_if.sv @@
// Interface: filtered result channel.
`timescale 1ns / 1ps
interface boc_out_if
  import boc_pkg::*;
;
  logic    valid;
  logic    ready;
  sample_t smoothed_value;

  modport source (output valid, output smoothed_value, input ready);
  modport sink   (input valid, input smoothed_value, output ready);
endinterface

@@ rtl/boc_cfg_if.sv @@
// Interface: configuration register write channel.
`timescale 1ns / 1ps
interface boc_cfg_if
  import boc_pkg::*;
;
  logic                     valid;
  logic                     ready;
  cfg_index_t               index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/boxcar_or_exponential_smoother_top.sv @@
// Top level: boxcar moving average / exponential smoothing filter.
//
// Samples enter on the samples channel (valid/ready); a set record_start
// clears all filter history before the sample is used. Results leave on the
// smoothed channel through an output register. Registers are written on the
// cfg channel (index 0 filter_mode, 1 window_length, 2 smoothing_weight),
// which is ready outside reset and must only be used while the block is idle.
// One sample is taken at a time. A boxcar result reaches the output register
// after 4 sequencer steps (difference, multiply, accumulate, final) and 29
// steps of the restoring divider between the last two (one quotient bit per
// cycle). An exponential result, or a boxcar sample that gives no result while
// the window fills, skips the divider. The next sample is accepted once the
// sequencer has returned to idle. When the receiver stalls, the result holds in
// the output register and a following item waits at its final step until
// the register frees. Reset (rst, synchronous) clears the sequencer, the
// pointers, totals and registers; the history memory needs no clearing.
`timescale 1ns / 1ps
module boxcar_or_exponential_smoother_top
  import boc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  boc_in_if.sink    samples,
  boc_out_if.source smoothed,
  boc_cfg_if.sink   cfg
);

  typedef enum logic [2:0] {
    S_IDLE, S_DIFF, S_MUL, S_ACC, S_DIV, S_DONE
  } state_t;

  localparam int CNT_BITS = $clog2(TOTAL_BITS);

  state_t                   state;
  logic                     filter_mode;
  logic [WIN_BITS-1:0]      window_length;
  logic [WEIGHT_BITS-1:0]   smoothing_weight;

  logic [ADDR_BITS-1:0]     history_pointer;
  logic [WIN_BITS-1:0]      fill_count;
  logic [TOTAL_BITS-1:0]    running_total;
  logic [ACC_BITS-1:0]      smooth_accumulator;
  logic                     smoothing_started;

  sample_t                  history_line [MAX_WINDOW];
  sample_t                  leave_sample;

  sample_t                  x;
  logic [WIN_BITS-1:0]      n;
  logic [WEIGHT_BITS-1:0]   w;
  logic                     sub_en;
  logic                     box_ready;
  logic signed [ACC_BITS:0] diff;
  logic signed [ACC_BITS+WEIGHT_BITS+1:0] prod;

  logic [TOTAL_BITS-1:0]    quot;
  logic [WIN_BITS-1:0]      rem;
  logic                     box_neg;
  logic [CNT_BITS-1:0]      cnt;

  logic                     out_valid;
  sample_t                  out_value;

  logic                     accept;
  logic                     start;
  logic [WIN_BITS-1:0]      n_eff;
  logic [WEIGHT_BITS-1:0]   w_eff;
  logic [ADDR_BITS-1:0]     ptr_eff;
  logic [WIN_BITS-1:0]      fill_eff;
  logic [WIN_BITS-1:0]      fill_next;
  logic [ADDR_BITS-1:0]     leave_addr;
  logic [TOTAL_BITS-1:0]    x_ext;
  logic [TOTAL_BITS-1:0]    leave_ext;
  logic [WIN_BITS:0]        trial;
  logic                     ge;
  logic [TOTAL_BITS-1:0]    quot_neg;
  sample_t                  box_value;
  logic                     emit;
  logic                     load_out;

  localparam logic [TOTAL_BITS-1:0] SMAX_MAG = TOTAL_BITS'((1 << (SAMPLE_BITS-1)) - 1);
  localparam logic [TOTAL_BITS-1:0] SMIN_MAG = TOTAL_BITS'(1 << (SAMPLE_BITS-1));

  assign accept         = samples.valid && samples.ready;
  assign samples.ready  = (state == S_IDLE) && !rst;
  assign cfg.ready      = !rst;
  assign smoothed.valid = out_valid;
  assign smoothed.smoothed_value = out_value;

  always_comb begin
    start = samples.record_start;
    if (window_length == '0) begin
      n_eff = WIN_BITS'(1);
    end else if (window_length > WIN_BITS'(MAX_WINDOW)) begin
      n_eff = WIN_BITS'(MAX_WINDOW);
    end else begin
      n_eff = window_length;
    end
    w_eff      = (smoothing_weight > WEIGHT_ONE) ? WEIGHT_ONE : smoothing_weight;
    ptr_eff    = start ? '0 : history_pointer;
    fill_eff   = start ? '0 : fill_count;
    fill_next  = (fill_eff < WIN_BITS'(MAX_WINDOW)) ? fill_eff + 1'b1 : fill_eff;
    leave_addr = ptr_eff - n_eff[ADDR_BITS-1:0];

    x_ext     = {{(TOTAL_BITS-SAMPLE_BITS){x[SAMPLE_BITS-1]}}, x};
    leave_ext = {{(TOTAL_BITS-SAMPLE_BITS){leave_sample[SAMPLE_BITS-1]}}, leave_sample};

    trial = {rem, quot[TOTAL_BITS-1]};
    ge    = (trial >= {1'b0, n});

    quot_neg = ~quot + 1'b1;
    if (!box_neg) begin
      box_value = (quot > SMAX_MAG) ? sample_t'(SMAX_MAG[SAMPLE_BITS-1:0])
                                    : sample_t'(quot[SAMPLE_BITS-1:0]);
    end else begin
      box_value = (quot > SMIN_MAG) ? sample_t'(SMIN_MAG[SAMPLE_BITS-1:0])
                                    : sample_t'(quot_neg[SAMPLE_BITS-1:0]);
    end
    emit     = filter_mode || box_ready;
    load_out = (state == S_DONE) && (!out_valid || smoothed.ready) && emit;
  end

  // History memory: write the new sample, read the one leaving the window.
  always_ff @(posedge clk) begin
    if (accept) begin
      history_line[ptr_eff] <= samples.sample_value;
      leave_sample          <= history_line[leave_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      filter_mode        <= 1'b0;
      window_length      <= WIN_BITS'(8);
      smoothing_weight   <= WEIGHT_BITS'(32768);
      history_pointer    <= '0;
      fill_count         <= '0;
      running_total      <= '0;
      smooth_accumulator <= '0;
      smoothing_started  <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          CFG_FILTER_MODE:      filter_mode      <= cfg.data[0];
          CFG_WINDOW_LENGTH:    window_length    <= cfg.data[WIN_BITS-1:0];
          CFG_SMOOTHING_WEIGHT: smoothing_weight <= cfg.data[WEIGHT_BITS-1:0];
          default: ;
        endcase
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && smoothed.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            x               <= samples.sample_value;
            n               <= n_eff;
            w               <= w_eff;
            sub_en          <= (fill_eff >= n_eff);
            box_ready       <= (fill_next >= n_eff);
            history_pointer <= ptr_eff + 1'b1;
            fill_count      <= fill_next;
            if (start) begin
              running_total      <= '0;
              smooth_accumulator <= '0;
              smoothing_started  <= 1'b0;
            end
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          running_total <= running_total - (sub_en ? leave_ext : '0) + x_ext;
          diff  <= $signed({x[SAMPLE_BITS-1], x, {FRAC_BITS{1'b0}}})
                 - $signed({smooth_accumulator[ACC_BITS-1], smooth_accumulator});
          state <= S_MUL;
        end
        S_MUL: begin
          prod    <= diff * $signed({1'b0, w});
          box_neg <= running_total[TOTAL_BITS-1];
          quot    <= running_total[TOTAL_BITS-1] ? ~running_total + 1'b1 : running_total;
          rem     <= '0;
          cnt     <= CNT_BITS'(TOTAL_BITS - 1);
          state   <= S_ACC;
        end
        S_ACC: begin
          if (!smoothing_started) begin
            smooth_accumulator <= {x, {FRAC_BITS{1'b0}}};
          end else begin
            smooth_accumulator <= smooth_accumulator + prod[ACC_BITS+FRAC_BITS-1:FRAC_BITS];
          end
          smoothing_started <= 1'b1;
          state <= (!filter_mode && box_ready) ? S_DIV : S_DONE;
        end
        S_DIV: begin
          rem  <= ge ? WIN_BITS'(trial - {1'b0, n}) : trial[WIN_BITS-1:0];
          quot <= {quot[TOTAL_BITS-2:0], ge};
          if (cnt == '0) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid || smoothed.ready) begin
            if (emit) begin
              out_value <= filter_mode ? sample_t'(smooth_accumulator[ACC_BITS-1:FRAC_BITS])
                                       : box_value;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= WIN_BITS'(MAX_WINDOW))
    else $error("fill count above window depth");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < n))
    else $error("divider remainder not below divisor");

  a_started: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> smoothing_started)
    else $error("smoother not started at result step");

  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result raised outside final step");

endmodule

@@ tb/boxcar_or_exponential_smoother_top_tb.sv @@
// Testbench: random and directed regression of the boxcar / exponential smoother top.
`timescale 1ns / 1ps
module boxcar_or_exponential_smoother_top_tb
  import boc_pkg::*;
;

  localparam logic MODE_BOXCAR      = 1'b0;
  localparam logic MODE_EXPONENTIAL = 1'b1;
  localparam int   RANDOM_PHASES    = 12;
  localparam int   SETTLE_CYCLES    = 40;
  localparam int   LONG_HOLD_CYCLES = 400;
  localparam int   LONG_HOLD_MARK   = 60;

  typedef struct packed {
    sample_t value;
    logic    start;
  } sample_item_t;

  logic clk = 1'b0;
  logic rst;

  boc_in_if  samples();
  boc_out_if smoothed();
  boc_cfg_if cfg();

  boxcar_or_exponential_smoother_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples),
    .smoothed (smoothed),
    .cfg      (cfg)
  );

  always #4 clk = ~clk;

  sample_item_t pending_samples[$];
  sample_t      smoothed_expect[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int samples_taken  = 0;
  int mismatch_count = 0;
  int hold_left;
  logic hold_done;

  logic                   mode_reg;
  logic [WIN_BITS-1:0]    window_reg;
  logic [WEIGHT_BITS-1:0] weight_reg;

  sample_t               hist_line [MAX_WINDOW];
  logic [ADDR_BITS-1:0]  hist_ptr;
  logic [WIN_BITS-1:0]   fill_cnt;
  logic [TOTAL_BITS-1:0] box_total;
  longint                exp_acc;
  logic                  exp_started;

  function automatic void smooth_sample(input sample_t x, input logic start);
    int unsigned          n;
    longint               w;
    longint               box_val;
    longint               diff;
    logic [ADDR_BITS-1:0] leave;
    logic                 box_ready;
    n = (window_reg == 0) ? 1 : (window_reg > MAX_WINDOW) ? MAX_WINDOW : window_reg;
    w = (weight_reg > WEIGHT_ONE) ? longint'(WEIGHT_ONE) : longint'(weight_reg);
    if (start) begin
      hist_ptr    = '0;
      fill_cnt    = '0;
      box_total   = '0;
      exp_acc     = 0;
      exp_started = 1'b0;
    end
    if (fill_cnt >= n) begin
      leave     = hist_ptr - ADDR_BITS'(n);
      box_total = TOTAL_BITS'(longint'(box_total) - longint'(hist_line[leave]));
    end
    hist_line[hist_ptr] = x;
    box_total = TOTAL_BITS'(longint'(box_total) + longint'(x));
    hist_ptr  = hist_ptr + 1'b1;
    if (fill_cnt < MAX_WINDOW) begin
      fill_cnt = fill_cnt + 1'b1;
    end
    box_ready = (fill_cnt >= n);
    box_val   = longint'($signed(box_total)) / longint'(n);
    if (box_val < -32768) begin
      box_val = -32768;
    end
    if (box_val > 32767) begin
      box_val = 32767;
    end
    if (!exp_started) begin
      exp_acc     = longint'(x) <<< FRAC_BITS;
      exp_started = 1'b1;
    end else begin
      diff    = (longint'(x) <<< FRAC_BITS) - exp_acc;
      exp_acc = exp_acc + ((diff * w) >>> FRAC_BITS);
    end
    if (mode_reg == MODE_EXPONENTIAL) begin
      smoothed_expect.push_back(sample_t'(exp_acc >>> FRAC_BITS));
    end else if (box_ready) begin
      smoothed_expect.push_back(sample_t'(box_val));
    end
  endfunction

  function automatic sample_t random_sample();
    case ($urandom_range(7))
      0: return 32767;
      1: return -32768;
      2: return sample_t'(int'($urandom_range(4)) - 2);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic add_item(input sample_t value, input logic start);
    pending_samples.push_back('{value: value, start: start});
  endtask

  task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] value);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      CFG_FILTER_MODE:      mode_reg   = value[0];
      CFG_WINDOW_LENGTH:    window_reg = value[WIN_BITS-1:0];
      CFG_SMOOTHING_WEIGHT: weight_reg = value[WEIGHT_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_samples.size() != 0 || samples.valid || smoothed_expect.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  always @(posedge clk) begin : sample_driver
    sample_item_t next_item;
    if (rst) begin
      samples.valid <= 1'b0;
    end else begin
      if (samples.valid && samples.ready) begin
        smooth_sample(samples.sample_value, samples.record_start);
        samples_taken <= samples_taken + 1;
      end
      if (!samples.valid || samples.ready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = pending_samples.pop_front();
          samples.valid        <= 1'b1;
          samples.sample_value <= next_item.value;
          samples.record_start <= next_item.start;
        end else begin
          samples.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && samples_taken >= LONG_HOLD_MARK) begin
      hold_left <= LONG_HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_monitor
    sample_t want;
    if (rst) begin
      smoothed.ready <= 1'b0;
    end else begin
      if (smoothed.valid && smoothed.ready) begin
        if (smoothed_expect.size() == 0) begin
          $display("%0t: smoothed_value expected none, got %0d", $time,
                   smoothed.smoothed_value);
          mismatch_count++;
        end else begin
          want = smoothed_expect.pop_front();
          if (smoothed.smoothed_value !== want) begin
            $display("%0t: smoothed_value expected %0d, got %0d", $time, want,
                     smoothed.smoothed_value);
            mismatch_count++;
          end
        end
      end
      smoothed.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #4_000_000;
    $display("boxcar_or_exponential_smoother_top regression: fail");
    $finish;
  end

  initial begin
    int   p;
    int   count;
    int   record_left;
    int   win_val;
    int   n_eff;
    logic big;
    logic start_flag;
    logic mode_val;
    logic [CFG_DATA_BITS-1:0] weight_val;

    samples.valid        = 1'b0;
    samples.sample_value = '0;
    samples.record_start = 1'b0;
    smoothed.ready       = 1'b0;
    cfg.valid            = 1'b0;
    cfg.index            = CFG_FILTER_MODE;
    cfg.data             = '0;
    mode_reg    = MODE_BOXCAR;
    window_reg  = 9'd8;
    weight_reg  = 17'd32768;
    hist_ptr    = '0;
    fill_cnt    = '0;
    box_total   = '0;
    exp_acc     = 0;
    exp_started = 1'b0;
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    add_item(32767, 1'b1);
    add_item(-32768, 1'b0);
    add_item(32767, 1'b0);
    add_item(-32768, 1'b0);
    add_item(-1, 1'b0);
    add_item(0, 1'b0);
    add_item(1, 1'b0);
    add_item(32767, 1'b0);
    add_item(32767, 1'b0);
    add_item(-32768, 1'b0);
    wait_drained();

    write_register(CFG_FILTER_MODE, {16'h0000, MODE_EXPONENTIAL});
    write_register(CFG_SMOOTHING_WEIGHT, 17'h1FFFF);
    add_item(-32768, 1'b1);
    add_item(32767, 1'b0);
    add_item(-32768, 1'b0);
    wait_drained();

    write_register(CFG_SMOOTHING_WEIGHT, 17'd0);
    add_item(100, 1'b1);
    add_item(-32768, 1'b0);
    wait_drained();

    write_register(CFG_FILTER_MODE, {16'hFFFF, MODE_BOXCAR});
    write_register(CFG_WINDOW_LENGTH, 17'h1FE00);
    add_item(5, 1'b1);
    add_item(-7, 1'b0);
    add_item(32767, 1'b0);
    wait_drained();

    write_register(CFG_WINDOW_LENGTH, 17'd2);
    add_item(10, 1'b1);
    add_item(20, 1'b0);
    add_item(30, 1'b0);
    wait_drained();

    // switch window and mode inside the open record
    write_register(CFG_WINDOW_LENGTH, 17'd3);
    write_register(CFG_FILTER_MODE, {16'h0000, MODE_EXPONENTIAL});
    write_register(CFG_SMOOTHING_WEIGHT, 17'd40000);
    add_item(40, 1'b0);
    add_item(50, 1'b0);
    wait_drained();

    write_register(CFG_FILTER_MODE, {16'h0000, MODE_BOXCAR});
    add_item(-60, 1'b0);
    add_item(70, 1'b0);
    wait_drained();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      big = (p % 6 == 2);
      case (p % 6)
        0: win_val = 1;
        1: win_val = 2;
        2: win_val = (p == 2) ? MAX_WINDOW : $urandom_range(MAX_WINDOW + 1, 511);
        3: win_val = 0;
        default: win_val = $urandom_range(3, 40);
      endcase
      case ((p + p / 4) % 4)
        0: weight_val = 17'd0;
        1: weight_val = 17'd65536;
        2: weight_val = 17'($urandom_range(65537, 131071));
        default: weight_val = 17'($urandom_range(1, 65535));
      endcase
      mode_val = big ? MODE_BOXCAR : ($urandom_range(1) ? MODE_EXPONENTIAL : MODE_BOXCAR);
      write_register(CFG_FILTER_MODE, {16'($urandom), mode_val});
      write_register(CFG_WINDOW_LENGTH, {8'($urandom), 9'(win_val)});
      write_register(CFG_SMOOTHING_WEIGHT, weight_val);
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 58;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 58;
        end
        default: begin
          send_idle_pct  = 28;
          recv_stall_pct = 28;
        end
      endcase
      n_eff = big ? MAX_WINDOW : ((win_val == 0) ? 1 : win_val);
      count = big ? 330 : 110;
      // carry the open record across the register writes now and then
      record_left = ($urandom_range(9) < 7) ? 0 : $urandom_range(1, 3 * n_eff + 8);
      repeat (count) begin
        start_flag = (record_left == 0) || ($urandom_range(39) == 0);
        if (start_flag) begin
          record_left = big ? $urandom_range(256, 320) : $urandom_range(1, 3 * n_eff + 8);
        end
        add_item(random_sample(), start_flag);
        record_left--;
      end
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("boxcar_or_exponential_smoother_top regression: pass");
    end else begin
      $display("boxcar_or_exponential_smoother_top regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/boc_pkg.sv
rtl/boc_in_if.sv
rtl/boc_out_if.sv
rtl/boc_cfg_if.sv
rtl/boxcar_or_exponential_smoother_top.sv
tb/boxcar_or_exponential_smoother_top_tb.sv
